// ===== rtl/eti_pkg.sv =====
// Shared types and constants for the three-point uniform-grid interpolator.
// Used by the channel interfaces and every module of the block; no dependencies.
package eti_pkg;

    // Sample table geometry
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned TABLE_DEPTH = 2 ** INDEX_W;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POINTS_W = 7;
    localparam int unsigned CFG_INDEX_W = 2;

    // Grid coordinate u and centre-relative t
    localparam int unsigned UQ_W = 50;
    localparam int unsigned CR_W = UQ_W - 16;
    localparam int unsigned TQ_W = 24;
    localparam int          T_LIMIT = 64 * 65536;

    // Weighted sum of three products; stays below 2^62 in magnitude
    localparam int unsigned SUM_W = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VALUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLOPE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_START   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINTS       = 2'd2;

    // Number of register stages in the combine section
    localparam int unsigned CMB_STAGES = 7;

    typedef struct packed {
        logic signed [DATA_W-1:0] grid_start;
        logic        [DATA_W-1:0] inverse_step;
        logic      [POINTS_W-1:0] points_in_use;
    } cfg_t;

    typedef struct packed {
        logic        [CMD_W-1:0]   command;
        logic        [INDEX_W-1:0] entry_index;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [DATA_W-1:0]  query_x;
    } req_t;

    // Located query (or pending table write) handed to the sample store
    typedef struct packed {
        logic        [CMD_W-1:0]   command;
        logic        [INDEX_W-1:0] entry_index;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [UQ_W-1:0]    uq;
        logic        [INDEX_W-1:0] centre;
    } loc_item_t;

    // Offset and neighboring samples handed to the combine section
    typedef struct packed {
        logic                     slope;
        logic signed [TQ_W-1:0]   tq;
        logic signed [DATA_W-1:0] y0;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
    } pt_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
    } rsp_t;

endpackage

// ===== rtl/eti_in_if.sv =====
// Request channel: valid/ready handshake with command and operand payload.
// Depends on eti_pkg.
interface eti_in_if;
    import eti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [CMD_W-1:0]   command;
    logic        [INDEX_W-1:0] entry_index;
    logic signed [DATA_W-1:0]  entry_value;
    logic signed [DATA_W-1:0]  query_x;

    modport source (output valid, output command, output entry_index,
                    output entry_value, output query_x, input ready);
    modport sink   (input valid, input command, input entry_index,
                    input entry_value, input query_x, output ready);
endinterface

// ===== rtl/eti_out_if.sv =====
// Result channel: valid/ready handshake with result value and saturation flag.
// Depends on eti_pkg.
interface eti_out_if;
    import eti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;

    modport source (output valid, output result_value, output saturated, input ready);
    modport sink   (input valid, input result_value, input saturated, output ready);
endinterface

// ===== rtl/eti_locate.sv =====
// Four-stage front end: grid coordinate u = (x - start) * inverse_step, then centre index.
// Depends on eti_pkg.
module eti_locate (
    input  logic               clk,
    input  logic               rst_n,
    input  eti_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  eti_pkg::req_t      in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output eti_pkg::loc_item_t out_item
);
    import eti_pkg::*;

    // Stage valid bits and load enables (A, B, C, D)
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_valid_next;
    logic a_en, b_en, c_en, d_en;

    // Stage A: difference to grid start as sign and magnitude
    logic signed [DATA_W:0] a_diff;
    logic        [DATA_W:0] a_mag_full;
    logic                   a_neg_next;
    logic  [CMD_W-1:0]      a_cmd_reg;
    logic  [INDEX_W-1:0]    a_index_reg;
    logic  [DATA_W-1:0]     a_value_reg;
    logic                   a_neg_reg;
    logic  [DATA_W-1:0]     a_mag_reg;

    // Stage B: unsigned product with the inverse step
    logic [2*DATA_W-1:0]    b_prod_next;
    logic [CMD_W-1:0]       b_cmd_reg;
    logic [INDEX_W-1:0]     b_index_reg;
    logic [DATA_W-1:0]      b_value_reg;
    logic                   b_neg_reg;
    logic [2*DATA_W-1:0]    b_prod_reg;

    // Stage C: floor to signed Q34.16
    logic [2*DATA_W:0]      c_up;
    logic [UQ_W-1:0]        c_neg_uq;
    logic signed [UQ_W-1:0] c_uq_next;
    logic [CMD_W-1:0]       c_cmd_reg;
    logic [INDEX_W-1:0]     c_index_reg;
    logic [DATA_W-1:0]      c_value_reg;
    logic signed [UQ_W-1:0] c_uq_reg;

    // Stage D: round to nearest sample and clamp to the usable range
    logic signed [UQ_W-1:0] d_sum;
    logic signed [CR_W-1:0] d_round;
    logic [POINTS_W-1:0]    d_points;
    logic [POINTS_W-1:0]    d_max_full;
    logic [INDEX_W-1:0]     d_max;
    logic [INDEX_W-1:0]     d_centre_next;
    logic [CMD_W-1:0]       d_cmd_reg;
    logic [INDEX_W-1:0]     d_index_reg;
    logic [DATA_W-1:0]      d_value_reg;
    logic signed [UQ_W-1:0] d_uq_reg;
    logic [INDEX_W-1:0]     d_centre_reg;

    // Advance a stage when it is empty or its successor advances
    assign d_en     = !d_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // Drop the unused command code at entry
    assign a_valid_next = in_valid && (in_item.command == CMD_WRITE
                                    || in_item.command == CMD_VALUE
                                    || in_item.command == CMD_SLOPE);

    always_comb
    begin
        a_diff = $signed({in_item.query_x[DATA_W-1], in_item.query_x})
               - $signed({cfg.grid_start[DATA_W-1], cfg.grid_start});
        a_neg_next = a_diff[DATA_W];
        a_mag_full = a_neg_next ? (~a_diff + (DATA_W+1)'(1)) : a_diff;
    end

    assign b_prod_next = (2*DATA_W)'(a_mag_reg) * (2*DATA_W)'(cfg.inverse_step);

    // Negative side rounds the magnitude up so that u is a floor
    always_comb
    begin
        c_up      = {1'b0, b_prod_reg} + (2*DATA_W+1)'(16'hFFFF);
        c_neg_uq  = ~({1'b0, c_up[2*DATA_W:16]}) + UQ_W'(1);
        c_uq_next = b_neg_reg ? $signed(c_neg_uq)
                              : $signed({2'b00, b_prod_reg[2*DATA_W-1:16]});
    end

    always_comb
    begin
        d_sum   = c_uq_reg + $signed(UQ_W'(32'h8000));
        d_round = d_sum[UQ_W-1:16];
        if (cfg.points_in_use < POINTS_W'(3))
        begin
            d_points = POINTS_W'(3);
        end
        else if (cfg.points_in_use > POINTS_W'(TABLE_DEPTH))
        begin
            d_points = POINTS_W'(TABLE_DEPTH);
        end
        else
        begin
            d_points = cfg.points_in_use;
        end
        d_max_full = d_points - POINTS_W'(2);
        d_max      = d_max_full[INDEX_W-1:0];
        if (d_round < $signed(CR_W'(1)))
        begin
            d_centre_next = INDEX_W'(1);
        end
        else if (d_round > $signed({{(CR_W-INDEX_W){1'b0}}, d_max}))
        begin
            d_centre_next = d_max;
        end
        else
        begin
            d_centre_next = d_round[INDEX_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= a_valid_next;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_cmd_reg   <= in_item.command;
            a_index_reg <= in_item.entry_index;
            a_value_reg <= in_item.entry_value;
            a_neg_reg   <= a_neg_next;
            a_mag_reg   <= a_mag_full[DATA_W-1:0];
        end
        if (b_en)
        begin
            b_cmd_reg   <= a_cmd_reg;
            b_index_reg <= a_index_reg;
            b_value_reg <= a_value_reg;
            b_neg_reg   <= a_neg_reg;
            b_prod_reg  <= b_prod_next;
        end
        if (c_en)
        begin
            c_cmd_reg   <= b_cmd_reg;
            c_index_reg <= b_index_reg;
            c_value_reg <= b_value_reg;
            c_uq_reg    <= c_uq_next;
        end
        if (d_en)
        begin
            d_cmd_reg    <= c_cmd_reg;
            d_index_reg  <= c_index_reg;
            d_value_reg  <= c_value_reg;
            d_uq_reg     <= c_uq_reg;
            d_centre_reg <= d_centre_next;
        end
    end

    assign out_valid            = d_valid_reg;
    assign out_item.command     = d_cmd_reg;
    assign out_item.entry_index = d_index_reg;
    assign out_item.entry_value = d_value_reg;
    assign out_item.uq          = d_uq_reg;
    assign out_item.centre      = d_centre_reg;

endmodule

// ===== rtl/eti_sample_store.sv =====
// Sample table stage: applies table writes and reads the three neighbors of a query.
// Holds three copies of the table, one per read port. Depends on eti_pkg.
module eti_sample_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  eti_pkg::loc_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output eti_pkg::pt_item_t  out_item
);
    import eti_pkg::*;

    localparam logic signed [UQ_W-1:0] T_HI = UQ_W'(T_LIMIT);
    localparam logic signed [UQ_W-1:0] T_LO = -UQ_W'(T_LIMIT);

    logic [DATA_W-1:0] table0_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] table1_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] table2_mem [TABLE_DEPTH];

    logic                   load;
    logic                   is_write;
    logic                   is_query;
    logic [INDEX_W-1:0]     addr0;
    logic [INDEX_W-1:0]     addr2;
    logic signed [UQ_W-1:0] t_full;
    logic [TQ_W-1:0]        tq_next;

    logic                   valid_reg;
    logic                   slope_reg;
    logic [TQ_W-1:0]        tq_reg;
    logic [DATA_W-1:0]      y0_reg;
    logic [DATA_W-1:0]      y1_reg;
    logic [DATA_W-1:0]      y2_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign is_write = in_item.command == CMD_WRITE;
    assign is_query = !is_write;
    assign addr0    = in_item.centre - INDEX_W'(1);
    assign addr2    = in_item.centre + INDEX_W'(1);

    // Offset from the centre sample, clamped for far extrapolation
    always_comb
    begin
        t_full = in_item.uq - $signed({{(UQ_W-INDEX_W-16){1'b0}}, in_item.centre, 16'h0000});
        if (t_full > T_HI)
        begin
            tq_next = T_HI[TQ_W-1:0];
        end
        else if (t_full < T_LO)
        begin
            tq_next = T_LO[TQ_W-1:0];
        end
        else
        begin
            tq_next = t_full[TQ_W-1:0];
        end
    end

    // Writes leave the pipeline here; queries move on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid && is_query;
        end
    end

    // Table copies: written together, each read at one neighbor address
    always_ff @(posedge clk)
    begin
        if (load && is_write)
        begin
            table0_mem[in_item.entry_index] <= in_item.entry_value;
            table1_mem[in_item.entry_index] <= in_item.entry_value;
            table2_mem[in_item.entry_index] <= in_item.entry_value;
        end
        if (in_ready)
        begin
            y0_reg    <= table0_mem[addr0];
            y1_reg    <= table1_mem[in_item.centre];
            y2_reg    <= table2_mem[addr2];
            slope_reg <= in_item.command == CMD_SLOPE;
            tq_reg    <= tq_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_item.slope = slope_reg;
    assign out_item.tq    = $signed(tq_reg);
    assign out_item.y0    = $signed(y0_reg);
    assign out_item.y1    = $signed(y1_reg);
    assign out_item.y2    = $signed(y2_reg);

endmodule

// ===== rtl/eti_combine.sv =====
// Seven-stage back end: Lagrange weights, weighted sum, scaling, rounding and saturation.
// Depends on eti_pkg.
module eti_combine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [eti_pkg::DATA_W-1:0] inverse_step,
    input  logic              in_valid,
    output logic              in_ready,
    input  eti_pkg::pt_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output eti_pkg::rsp_t     out_item
);
    import eti_pkg::*;

    localparam int unsigned SQ_W = 2 * TQ_W - 3;
    localparam int unsigned TT_W = SQ_W - 16;
    localparam int unsigned VR_W = SUM_W - 17;

    // Stage order: 0 square, 1 weights, 2 products, 3 sum, 4 magnitude,
    // 5 round or scale, 6 saturate
    logic [CMB_STAGES-1:0] valid_reg;
    logic [CMB_STAGES-1:0] valid_next;
    logic [CMB_STAGES-1:0] en;

    // Stage 0
    logic signed [2*TQ_W-1:0] sq_full;
    logic                     s0_slope_reg;
    logic signed [TQ_W-1:0]   s0_tq_reg;
    logic [SQ_W-1:0]          s0_sq_reg;
    logic signed [DATA_W-1:0] s0_y0_reg, s0_y1_reg, s0_y2_reg;

    // Stage 1
    logic [SQ_W:0]            tt_sum;
    logic signed [DATA_W-1:0] tt_s, tq_s;
    logic signed [DATA_W-1:0] w0_next, w1_next, w2_next;
    logic                     s1_slope_reg;
    logic signed [DATA_W-1:0] s1_w0_reg, s1_w1_reg, s1_w2_reg;
    logic signed [DATA_W-1:0] s1_y0_reg, s1_y1_reg, s1_y2_reg;

    // Stage 2
    logic signed [SUM_W-1:0]  p0_next, p1_next, p2_next;
    logic                     s2_slope_reg;
    logic signed [SUM_W-1:0]  s2_p0_reg, s2_p1_reg, s2_p2_reg;

    // Stage 3
    logic                     s3_slope_reg;
    logic signed [SUM_W-1:0]  s3_sum_reg;

    // Stage 4
    logic [SUM_W-1:0]         mag_next;
    logic                     s4_slope_reg;
    logic                     s4_neg_reg;
    logic [SUM_W-1:0]         s4_mag_reg;

    // Stage 5
    logic [SUM_W-1:0]         vr_sum;
    logic                     s5_slope_reg;
    logic                     s5_neg_reg;
    logic [VR_W-1:0]          s5_vr_reg;
    logic [2*DATA_W-1:0]      s5_lo_reg;
    logic [2*DATA_W-1:0]      s5_hi_reg;

    // Stage 6
    logic [SUM_W-1:0]         amag;
    logic [DATA_W-1:0]        res_next;
    logic                     sat_next;
    logic [DATA_W-1:0]        s6_res_reg;
    logic                     s6_sat_reg;

    // Load enables: advance when empty or when the next stage advances
    always_comb
    begin
        en[CMB_STAGES-1] = !valid_reg[CMB_STAGES-1] || out_ready;
        for (int i = CMB_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = {valid_reg[CMB_STAGES-2:0], in_valid};
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < CMB_STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // Square the offset
    assign sq_full = (2*TQ_W)'(in_item.tq) * (2*TQ_W)'(in_item.tq);

    // Build the three weights: doubled Lagrange weights for a value,
    // derivative weights for a slope
    always_comb
    begin
        tt_sum = {1'b0, s0_sq_reg} + (SQ_W+1)'(16'h8000);
        tt_s   = $signed({{(DATA_W-TT_W){1'b0}}, tt_sum[SQ_W-1:16]});
        tq_s   = DATA_W'(s0_tq_reg);
        if (s0_slope_reg)
        begin
            w0_next = tq_s - $signed(DATA_W'(32768));
            w1_next = -(tq_s <<< 1);
            w2_next = tq_s + $signed(DATA_W'(32768));
        end
        else
        begin
            w0_next = tt_s - tq_s;
            w1_next = $signed(DATA_W'(131072)) - (tt_s <<< 1);
            w2_next = tt_s + tq_s;
        end
    end

    assign p0_next = SUM_W'(s1_w0_reg) * SUM_W'(s1_y0_reg);
    assign p1_next = SUM_W'(s1_w1_reg) * SUM_W'(s1_y1_reg);
    assign p2_next = SUM_W'(s1_w2_reg) * SUM_W'(s1_y2_reg);

    assign mag_next = s3_sum_reg[SUM_W-1] ? (~s3_sum_reg + SUM_W'(1)) : s3_sum_reg;

    assign vr_sum = s4_mag_reg + SUM_W'(65536);

    // Recombine, then clip to the signed 32-bit range
    always_comb
    begin
        if (s5_slope_reg)
        begin
            amag = s5_hi_reg + {{DATA_W{1'b0}}, s5_lo_reg[2*DATA_W-1:DATA_W]}
                 + SUM_W'(s5_lo_reg[DATA_W-1]);
        end
        else
        begin
            amag = {{(SUM_W-VR_W){1'b0}}, s5_vr_reg};
        end
        if (!s5_neg_reg && amag > SUM_W'(32'h7FFF_FFFF))
        begin
            sat_next = 1'b1;
            res_next = 32'h7FFF_FFFF;
        end
        else if (s5_neg_reg && amag > SUM_W'(32'h8000_0000))
        begin
            sat_next = 1'b1;
            res_next = 32'h8000_0000;
        end
        else
        begin
            sat_next = 1'b0;
            res_next = s5_neg_reg ? (~amag[DATA_W-1:0] + DATA_W'(1)) : amag[DATA_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_slope_reg <= in_item.slope;
            s0_tq_reg    <= in_item.tq;
            s0_sq_reg    <= sq_full[SQ_W-1:0];
            s0_y0_reg    <= in_item.y0;
            s0_y1_reg    <= in_item.y1;
            s0_y2_reg    <= in_item.y2;
        end
        if (en[1])
        begin
            s1_slope_reg <= s0_slope_reg;
            s1_w0_reg    <= w0_next;
            s1_w1_reg    <= w1_next;
            s1_w2_reg    <= w2_next;
            s1_y0_reg    <= s0_y0_reg;
            s1_y1_reg    <= s0_y1_reg;
            s1_y2_reg    <= s0_y2_reg;
        end
        if (en[2])
        begin
            s2_slope_reg <= s1_slope_reg;
            s2_p0_reg    <= p0_next;
            s2_p1_reg    <= p1_next;
            s2_p2_reg    <= p2_next;
        end
        if (en[3])
        begin
            s3_slope_reg <= s2_slope_reg;
            s3_sum_reg   <= s2_p0_reg + s2_p1_reg + s2_p2_reg;
        end
        if (en[4])
        begin
            s4_slope_reg <= s3_slope_reg;
            s4_neg_reg   <= s3_sum_reg[SUM_W-1];
            s4_mag_reg   <= mag_next;
        end
        if (en[5])
        begin
            s5_slope_reg <= s4_slope_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_vr_reg    <= vr_sum[SUM_W-1:17];
            s5_lo_reg    <= (2*DATA_W)'(s4_mag_reg[DATA_W-1:0]) * (2*DATA_W)'(inverse_step);
            s5_hi_reg    <= (2*DATA_W)'(s4_mag_reg[SUM_W-1:DATA_W])
                          * (2*DATA_W)'(inverse_step);
        end
        if (en[6])
        begin
            s6_res_reg <= res_next;
            s6_sat_reg <= sat_next;
        end
    end

    assign out_valid             = valid_reg[CMB_STAGES-1];
    assign out_item.result_value = $signed(s6_res_reg);
    assign out_item.saturated    = s6_sat_reg;

endmodule

// ===== rtl/equidistant_three_point_interp_unit.sv =====
// A request passes 12 register stages before its result is valid.
// Throughput: one request per cycle; stalls on the result side back up stage by stage.
// The 32x32 grid multiply and the split 64x32 slope scaling each hold a stage of their own.
// Table writes take one slot and give no result; a query reads the table after all earlier writes.
// Reset clears valid bits and returns config registers to their defaults (start 0,
// inverse step 1.0, 64 points); table contents are undefined until written.
// Depends on eti_pkg, eti_in_if, eti_out_if, eti_locate, eti_sample_store, eti_combine.
module equidistant_three_point_interp_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [eti_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eti_pkg::DATA_W-1:0]      cfg_data,
    eti_in_if.sink                          req,
    eti_out_if.source                       rsp
);
    import eti_pkg::*;

    logic [DATA_W-1:0]   grid_start_reg;
    logic [DATA_W-1:0]   inverse_step_reg;
    logic [POINTS_W-1:0] points_reg;
    cfg_t                cfg;

    req_t      req_item;
    loc_item_t loc_item;
    pt_item_t  pt_item;
    rsp_t      rsp_item;
    logic      loc_valid, loc_ready;
    logic      pt_valid, pt_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_start_reg   <= '0;
            inverse_step_reg <= DATA_W'(65536);
            points_reg       <= POINTS_W'(TABLE_DEPTH);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_GRID_START:   grid_start_reg   <= cfg_data;
                CFG_INVERSE_STEP: inverse_step_reg <= cfg_data;
                CFG_POINTS:       points_reg       <= cfg_data[POINTS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.grid_start    = $signed(grid_start_reg);
    assign cfg.inverse_step  = inverse_step_reg;
    assign cfg.points_in_use = points_reg;

    assign req_item.command     = req.command;
    assign req_item.entry_index = req.entry_index;
    assign req_item.entry_value = req.entry_value;
    assign req_item.query_x     = req.query_x;

    eti_locate u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (req_item),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_item  (loc_item)
    );

    eti_sample_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_item   (loc_item),
        .out_valid (pt_valid),
        .out_ready (pt_ready),
        .out_item  (pt_item)
    );

    eti_combine u_combine (
        .clk          (clk),
        .rst_n        (rst_n),
        .inverse_step (inverse_step_reg),
        .in_valid     (pt_valid),
        .in_ready     (pt_ready),
        .in_item      (pt_item),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_item     (rsp_item)
    );

    assign rsp.result_value = rsp_item.result_value;
    assign rsp.saturated    = rsp_item.saturated;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for equidistant_three_point_interp_unit: drives table writes,
// value and slope queries, checks every result against an in-bench fixed-point predictor.
// Depends on eti_pkg, eti_in_if, eti_out_if and the interpolator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eti_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int               DRAIN_CYCLES = 16;
    localparam int               CYCLE_LIMIT = 300000;
    localparam int               HOLD_CYCLES = 400;
    localparam longint           GRID_ONE = 65536;
    localparam longint           OFFSET_CLAMP = 64 * 65536;

    logic clk;
    logic rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    eti_in_if  req_ch ();
    eti_out_if rsp_ch ();

    equidistant_three_point_interp_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .rsp          (rsp_ch)
    );

    // Mirror of the block's table and registers
    logic signed [DATA_W-1:0]   sample_mirror [TABLE_DEPTH];
    logic signed [DATA_W-1:0]   cur_start;
    logic        [DATA_W-1:0]   cur_inv_step;
    logic        [POINTS_W-1:0] cur_points;

    rsp_t pending_results [$];
    int   mismatch_count;
    int   gap_pct;
    int   stall_pct;
    int   hold_left;
    int   cycle_count;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: long hold-off when requested, else random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", rsp_ch.result_value));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.result_value !== want.result_value)
                    report_mismatch($sformatf("result_value %h, want %h",
                                              rsp_ch.result_value, want.result_value));
                if (rsp_ch.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b, want %b (value %h)",
                                              rsp_ch.saturated, want.saturated,
                                              want.result_value));
            end
        end
    end

    function automatic longint points_clamped();
        longint n;
        n = longint'(cur_points);
        if (n < 3)
            n = 3;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Fixed-point value or slope at query abscissa qx; 0 when the command gives no result
    function automatic bit evaluate_grid_point(input logic [CMD_W-1:0] cmd,
                                               input logic signed [DATA_W-1:0] qx,
                                               output rsp_t res);
        longint       n, d, uq, centre, tq, y0, y1, y2, tt, s;
        logic [63:0]  mag;
        logic [63:0]  rounded;
        logic [127:0] scaled;
        bit           neg;
        res = '0;
        if (cmd != CMD_VALUE && cmd != CMD_SLOPE)
            return 1'b0;
        n = points_clamped();

        // Map to grid coordinate, rounding the coordinate toward minus infinity
        d = longint'(qx) - longint'(cur_start);
        neg = (d < 0);
        mag = neg ? -d : d;
        scaled = 128'(mag) * 128'(cur_inv_step);
        if (neg)
            uq = -longint'((scaled + 128'hFFFF) >> 16);
        else
            uq = longint'(scaled >> 16);

        centre = (uq + 32768) >>> 16;
        if (centre < 1)
            centre = 1;
        if (centre > n - 2)
            centre = n - 2;
        tq = uq - centre * GRID_ONE;
        if (tq > OFFSET_CLAMP)
            tq = OFFSET_CLAMP;
        if (tq < -OFFSET_CLAMP)
            tq = -OFFSET_CLAMP;

        y0 = longint'(sample_mirror[INDEX_W'(centre - 1)]);
        y1 = longint'(sample_mirror[INDEX_W'(centre)]);
        y2 = longint'(sample_mirror[INDEX_W'(centre + 1)]);

        if (cmd == CMD_VALUE)
        begin
            tt = (tq * tq + 32768) >>> 16;
            s = (tt - tq) * y0 + (131072 - 2 * tt) * y1 + (tt + tq) * y2;
            neg = (s < 0);
            mag = neg ? -s : s;
            rounded = (mag + 65536) >> 17;
        end
        else
        begin
            s = (tq - 32768) * y0 + (-2 * tq) * y1 + (tq + 32768) * y2;
            neg = (s < 0);
            mag = neg ? -s : s;
            scaled = 128'(mag) * 128'(cur_inv_step);
            rounded = 64'((scaled + 128'h8000_0000) >> 32);
        end

        // Clip to the signed 32-bit range
        if (!neg && rounded > 64'h7FFF_FFFF)
        begin
            res.result_value = 32'h7FFF_FFFF;
            res.saturated = 1'b1;
        end
        else if (neg && rounded > 64'h8000_0000)
        begin
            res.result_value = 32'h8000_0000;
            res.saturated = 1'b1;
        end
        else
        begin
            res.result_value = neg ? (32'd0 - rounded[31:0]) : rounded[31:0];
        end
        return 1'b1;
    endfunction

    // Offer one request with random gaps before it; update the mirror on transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] value,
                             input logic signed [DATA_W-1:0] qx);
        rsp_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.entry_index <= idx;
        req_ch.entry_value <= value;
        req_ch.query_x     <= qx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (cmd == CMD_WRITE)
            sample_mirror[idx] = value;
        else if (evaluate_grid_point(cmd, qx, res))
            pending_results.push_back(res);
    endtask

    // Drop valid, wait for all results, then let trailing writes leave the pipeline
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back; call only while idle
    task automatic apply_grid(input logic signed [DATA_W-1:0] start,
                              input logic [DATA_W-1:0] inv_step,
                              input logic [POINTS_W-1:0] points);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_GRID_START;
        cfg_data     <= start;
        @(posedge clk);
        cfg_index    <= CFG_INVERSE_STEP;
        cfg_data     <= inv_step;
        @(posedge clk);
        cfg_index    <= CFG_POINTS;
        cfg_data     <= {{(DATA_W - POINTS_W){1'b0}}, points};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_start    = start;
        cur_inv_step = inv_step;
        cur_points   = points;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 30);
    endfunction

    // Mostly abscissae that land on or just beyond the table, some anywhere
    function automatic logic signed [DATA_W-1:0] pick_query();
        longint ugrid, x;
        if ($urandom_range(99) < 15 || cur_inv_step == 0)
            return $urandom;
        ugrid = longint'($urandom_range(0, 32'((points_clamped() + 2) * GRID_ONE)))
              - GRID_ONE;
        if ($urandom_range(9) == 0)
            ugrid = (ugrid & ~longint'(65535)) + 32768;
        x = longint'(cur_start) + (ugrid * GRID_ONE) / longint'(cur_inv_step);
        if (x > 64'sh7FFF_FFFF || x < -64'sh8000_0000)
            return $urandom;
        return x[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_inv_step();
        case ($urandom_range(5))
            0: return 32'd65536;
            1: return $urandom_range(1, 65535);
            2, 3: return $urandom_range(65536, 1 << 20);
            4: return $urandom_range(1 << 20, 32'hFFFF_FFFF);
            default: return $urandom_range(1, 1 << 18);
        endcase
    endfunction

    // Fill every entry so no query ever reads an unwritten sample
    task automatic test_table_fill();
        logic signed [DATA_W-1:0] v;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            case (k)
                0, 2, 62: v = 32'h7FFF_FFFF;
                1, 61, 63: v = 32'h8000_0000;
                default: v = rand_sample();
            endcase
            send_item(CMD_WRITE, INDEX_W'(k), v, $urandom);
        end
    endtask

    task automatic test_directed();
        // Reset grid: start 0, unit step, 64 points
        send_item(CMD_VALUE, 0, 0, 32'h8000_0000);
        send_item(CMD_SLOPE, 0, 0, 32'h8000_0000);
        send_item(CMD_VALUE, 0, 0, 32'h7FFF_FFFF);
        send_item(CMD_SLOPE, 0, 0, 32'h7FFF_FFFF);
        send_item(CMD_VALUE, 0, 0, 32'h0001_8000);
        send_item(CMD_SLOPE, 0, 0, 32'h0001_8000);
        send_item(CMD_VALUE, 0, 0, 32'h0001_4000);
        send_item(CMD_SLOPE, 0, 0, 32'h0020_8000);
        send_item(CMD_SPARE, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 40, 0, 0);
        send_item(CMD_VALUE, 0, 0, 32'h0028_0000);
        send_item(CMD_SLOPE, 0, 0, 32'h0027_C000);
        wait_idle();

        // Point count below range
        apply_grid(0, 32'd65536, 7'd0);
        send_item(CMD_VALUE, 0, 0, 32'h0001_0000);
        send_item(CMD_SLOPE, 0, 0, 32'h0010_0000);
        wait_idle();

        // Point count above range
        apply_grid(0, 32'd65536, 7'd127);
        send_item(CMD_VALUE, 0, 0, 32'h003F_8000);
        send_item(CMD_SLOPE, 0, 0, 32'h003E_0000);
        wait_idle();

        // Zero inverse step from the top of the abscissa range
        apply_grid(32'h7FFF_FFFF, 32'd0, 7'd64);
        send_item(CMD_VALUE, 0, 0, $urandom);
        send_item(CMD_SLOPE, 0, 0, $urandom);
        wait_idle();

        // Largest inverse step from the bottom of the abscissa range
        apply_grid(32'h8000_0000, 32'hFFFF_FFFF, 7'd64);
        send_item(CMD_VALUE, 0, 0, 32'h8000_0001);
        send_item(CMD_SLOPE, 0, 0, 32'h8000_0003);
        send_item(CMD_VALUE, 0, 0, 32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        int r;
        gap_pct = idle;
        stall_pct = stall;
        for (int blk = 0; blk < 2; blk++)
        begin
            apply_grid(signed'(32'($urandom)) >>> $urandom_range(4, 31), pick_inv_step(),
                       ($urandom_range(4) == 0) ? POINTS_W'($urandom_range(0, 127))
                                                : POINTS_W'($urandom_range(3, 64)));
            for (int i = 0; i < count / 2; i++)
            begin
                r = $urandom_range(99);
                if (r < 22)
                    send_item(CMD_WRITE, INDEX_W'($urandom), rand_sample(), $urandom);
                else if (r < 25)
                    send_item(CMD_SPARE, INDEX_W'($urandom), $urandom, $urandom);
                else
                    send_item(($urandom_range(1) == 0) ? CMD_VALUE : CMD_SLOPE,
                              INDEX_W'($urandom), $urandom, pick_query());
            end
            wait_idle();
        end
    endtask

    // Hold the result side off long enough to back the pipeline up into the request side
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        apply_grid(0, 32'd65536, 7'd64);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 120; i++)
            send_item(($urandom_range(1) == 0) ? CMD_VALUE : CMD_SLOPE, INDEX_W'($urandom),
                      $urandom, pick_query());
        wait_idle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = CFG_GRID_START;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_WRITE;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.query_x     = '0;
        rsp_ch.ready       = 1'b0;
        mismatch_count     = 0;
        gap_pct            = 0;
        stall_pct          = 0;
        hold_left          = 0;
        cycle_count        = 0;
        cur_start          = 0;
        cur_inv_step       = 32'd65536;
        cur_points         = 7'd64;
        foreach (sample_mirror[k])
            sample_mirror[k] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_table_fill();
        test_directed();
        test_random_traffic(0, 0, 300);
        test_random_traffic(64, 0, 300);
        test_random_traffic(0, 64, 300);
        test_random_traffic(24, 24, 300);
        test_backpressure();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eti_pkg.sv
rtl/eti_in_if.sv
rtl/eti_out_if.sv
rtl/eti_locate.sv
rtl/eti_sample_store.sv
rtl/eti_combine.sv
rtl/equidistant_three_point_interp_unit.sv
tb/sv/tb_top.sv
